[src/ucpd_pkg.sv]
// Package with the types, constants and helper function of the UTF-8 and percent decoder.
package ucpd_pkg;

  // Field widths and result buffer sizes.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CP_W      = 21;
  localparam int unsigned MAX_RES   = 4;
  localparam int unsigned RES_IDX_W = $clog2(MAX_RES);
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  // Characters and lead byte patterns.
  localparam logic [BYTE_W-1:0] PCT_CHAR   = 8'd37;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'd224;
  localparam logic [BYTE_W-1:0] LEAD2_FORM = 8'd192;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'd240;
  localparam logic [BYTE_W-1:0] LEAD3_FORM = 8'd224;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'd248;
  localparam logic [BYTE_W-1:0] LEAD4_FORM = 8'd240;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'd192;
  localparam logic [BYTE_W-1:0] CONT_FORM  = 8'd128;

  // Decoder modes.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_UTF  = 2'd1,
    MODE_PCT1 = 2'd2,
    MODE_PCT2 = 2'd3
  } mode_t;

  // Result of a hexadecimal digit lookup.
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Hexadecimal digit value of a byte: 0-9, a-f and A-F.
  function automatic hex_t hex_value(input logic [BYTE_W-1:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b >= 8'd48 && b <= 8'd57) begin
      h.val = 4'(b - 8'd48);
    end else if (b >= 8'd97 && b <= 8'd102) begin
      h.val = 4'(b - 8'd87);
    end else if (b >= 8'd65 && b <= 8'd70) begin
      h.val = 4'(b - 8'd55);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

[src/utf8_percent_code_point_decoder.sv]
// Top level of the UTF-8 and percent-escape code point decoder.
//
// Usage:
//   Bytes of text enter on the in_ stream, one request per byte; in_tlast
//   marks the last byte of the text and flushes any pending sequence.
//   Code points leave on the out_ stream; out_tlast marks the final result
//   caused by one input byte. A byte causes zero to four results.
// Timing and throughput:
//   The results of a byte appear in the cycle after it is accepted. The
//   decode is one combinational pass from the accepted byte and the decoder
//   state into a four-entry result buffer, so one byte is accepted per
//   cycle while each byte gives at most one result and out_tready is high.
//   The buffer drains one result per cycle while out_tready is high; the
//   next byte is taken in the cycle in which the last buffered result is taken.
// Reset:
//   rst_n low clears the decoder mode, counters, lead byte and the result
//   buffer; no results are pending afterwards.
// Stalls:
//   While out_tready is low the current result holds and in_tready drops
//   once no buffered result is about to leave.
module utf8_percent_code_point_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ucpd_pkg::IN_DATA_W-1:0]     in_tdata,   // data_byte[7:0]
  input  logic                               in_tlast,   // end_of_text
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ucpd_pkg::OUT_DATA_W-1:0]    out_tdata,  // code_point[20:0], was_raw[21], zero
  output logic                               out_tlast   // last_of_run
);
  import ucpd_pkg::*;

  // Decoder state.
  mode_t             mode_r,  mode_nxt;
  logic [1:0]        need_r,  need_nxt;
  logic [1:0]        held_r,  held_nxt;
  logic [BYTE_W-1:0] lead_r,  lead_nxt;
  logic [BYTE_W-1:0] hb0_r,   hb0_nxt;
  logic [BYTE_W-1:0] hb1_r,   hb1_nxt;

  // Result buffer.
  logic [CP_W-1:0]      buf_val_r [MAX_RES];
  logic                 buf_raw_r [MAX_RES];
  logic [RES_CNT_W-1:0] buf_cnt_r;
  logic [RES_IDX_W-1:0] buf_idx_r;

  // Results of the current byte.
  logic [CP_W-1:0]      res_val [MAX_RES];
  logic                 res_raw [MAX_RES];
  logic [RES_CNT_W-1:0] res_n;

  logic [BYTE_W-1:0] b;
  logic              eot;
  logic              in_accept;
  logic              out_pop;
  logic              is_cont;
  logic [CP_W-1:0]   combined;
  logic [CP_W-1:0]   comb_base;
  hex_t              hex_b;
  hex_t              hex_h0;

  // Fresh handling of a byte outside any sequence.
  logic              fresh_emit;
  logic [BYTE_W-1:0] fresh_val;
  logic              fresh_raw;
  mode_t             fresh_mode;
  logic [1:0]        fresh_need;

  assign b         = in_tdata[BYTE_W-1:0];
  assign eot       = in_tlast;
  assign in_accept = in_tvalid && in_tready;
  assign out_pop   = out_tvalid && out_tready;
  assign is_cont   = (b & CONT_MASK) == CONT_FORM;
  assign hex_b     = hex_value(b);
  assign hex_h0    = hex_value(hb0_r);

  // Handshake: take a byte when the buffer is empty or its last result leaves now.
  assign in_tready  = (buf_cnt_r == '0) ||
                      ((buf_cnt_r == RES_CNT_W'(1)) && out_tready);
  assign out_tvalid = buf_cnt_r != '0;
  assign out_tlast  = buf_cnt_r == RES_CNT_W'(1);
  assign out_tdata  = {{(OUT_DATA_W - CP_W - 1){1'b0}}, buf_raw_r[buf_idx_r],
                       buf_val_r[buf_idx_r]};

  // Classify a byte that starts afresh.
  always_comb begin
    fresh_emit = 1'b0;
    fresh_val  = b;
    fresh_raw  = 1'b0;
    fresh_mode = MODE_IDLE;
    fresh_need = 2'd0;
    if ((b & LEAD2_MASK) == LEAD2_FORM) begin
      fresh_need = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_FORM) begin
      fresh_need = 2'd2;
    end else if ((b & LEAD4_MASK) == LEAD4_FORM) begin
      fresh_need = 2'd3;
    end
    if (b == PCT_CHAR) begin
      if (eot) begin
        fresh_emit = 1'b1;
      end else begin
        fresh_mode = MODE_PCT1;
      end
    end else if (fresh_need == 2'd0) begin
      fresh_emit = 1'b1;
    end else if (eot) begin
      fresh_emit = 1'b1;
      fresh_raw  = 1'b1;
    end else begin
      fresh_mode = MODE_UTF;
    end
  end

  // Combine the lead byte, the held bytes and the final continuation byte.
  always_comb begin
    unique case (need_r)
      2'd1:    comb_base = CP_W'(lead_r[4:0]);
      2'd2:    comb_base = CP_W'(lead_r[3:0]);
      default: comb_base = CP_W'(lead_r[2:0]);
    endcase
    case (held_r)
      2'd0:    combined = {comb_base[14:0], b[5:0]};
      2'd1:    combined = {comb_base[8:0], hb0_r[5:0], b[5:0]};
      default: combined = {comb_base[2:0], hb0_r[5:0], hb1_r[5:0], b[5:0]};
    endcase
  end

  // Next decoder state and the results of the current byte.
  always_comb begin
    mode_nxt = mode_r;
    need_nxt = need_r;
    held_nxt = held_r;
    lead_nxt = lead_r;
    hb0_nxt  = hb0_r;
    hb1_nxt  = hb1_r;
    res_n    = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      res_val[i] = '0;
      res_raw[i] = 1'b0;
    end
    unique case (mode_r)
      MODE_UTF: begin
        if (is_cont && ({1'b0, held_r} + 3'd1 >= {1'b0, need_r})) begin
          // Sequence complete.
          res_val[0] = combined;
          res_n      = RES_CNT_W'(1);
          mode_nxt   = MODE_IDLE;
          held_nxt   = 2'd0;
          need_nxt   = 2'd0;
        end else if (is_cont && !eot) begin
          // Hold another continuation byte.
          if (held_r[0]) begin
            hb1_nxt = b;
          end else begin
            hb0_nxt = b;
          end
          held_nxt = held_r + 2'd1;
        end else begin
          // Abort: lead byte and held bytes go out raw first.
          res_val[0] = CP_W'(lead_r);
          res_raw[0] = 1'b1;
          res_val[1] = CP_W'(hb0_r);
          res_raw[1] = 1'b1;
          res_val[2] = CP_W'(hb1_r);
          res_raw[2] = 1'b1;
          res_n      = RES_CNT_W'(held_r) + RES_CNT_W'(1);
          mode_nxt   = MODE_IDLE;
          held_nxt   = 2'd0;
          need_nxt   = 2'd0;
          if (is_cont) begin
            // Text ended inside the sequence.
            res_val[RES_IDX_W'(res_n)] = CP_W'(b);
            res_raw[RES_IDX_W'(res_n)] = 1'b1;
            res_n = res_n + RES_CNT_W'(1);
          end else begin
            // The breaking byte is handled afresh.
            if (fresh_emit) begin
              res_val[RES_IDX_W'(res_n)] = CP_W'(fresh_val);
              res_raw[RES_IDX_W'(res_n)] = fresh_raw;
              res_n = res_n + RES_CNT_W'(1);
            end
            mode_nxt = fresh_mode;
            if (fresh_mode == MODE_UTF) begin
              lead_nxt = b;
              need_nxt = fresh_need;
            end
          end
        end
      end
      MODE_PCT1: begin
        if (eot) begin
          res_val[0] = hex_b.ok ? CP_W'(hex_b.val) : CP_W'(PCT_CHAR);
          res_n      = RES_CNT_W'(1);
          mode_nxt   = MODE_IDLE;
        end else begin
          hb0_nxt  = b;
          mode_nxt = MODE_PCT2;
        end
      end
      MODE_PCT2: begin
        if (!hex_h0.ok) begin
          res_val[0] = CP_W'(PCT_CHAR);
        end else if (!hex_b.ok) begin
          res_val[0] = CP_W'(hex_h0.val);
        end else begin
          res_val[0] = CP_W'({hex_h0.val, hex_b.val});
        end
        res_n    = RES_CNT_W'(1);
        mode_nxt = MODE_IDLE;
      end
      MODE_IDLE: begin
        if (fresh_emit) begin
          res_val[0] = CP_W'(fresh_val);
          res_raw[0] = fresh_raw;
          res_n      = RES_CNT_W'(1);
        end
        mode_nxt = fresh_mode;
        if (fresh_mode == MODE_UTF) begin
          lead_nxt = b;
          need_nxt = fresh_need;
          held_nxt = 2'd0;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase
  end

  // Decoder state register, updated on each accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      need_r <= 2'd0;
      held_r <= 2'd0;
      lead_r <= '0;
    end else if (in_accept) begin
      mode_r <= mode_nxt;
      need_r <= need_nxt;
      held_r <= held_nxt;
      lead_r <= lead_nxt;
    end
  end

  // Held bytes carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      hb0_r <= hb0_nxt;
      hb1_r <= hb1_nxt;
    end
  end

  // Result buffer control: load on a byte with results, else drain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r <= '0;
      buf_idx_r <= '0;
    end else if (in_accept && (res_n != '0)) begin
      buf_cnt_r <= res_n;
      buf_idx_r <= '0;
    end else if (out_pop) begin
      buf_cnt_r <= buf_cnt_r - RES_CNT_W'(1);
      buf_idx_r <= buf_idx_r + RES_IDX_W'(1);
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk) begin
    if (in_accept && (res_n != '0)) begin
      for (int i = 0; i < MAX_RES; i++) begin
        buf_val_r[i] <= res_val[i];
        buf_raw_r[i] <= res_raw[i];
      end
    end
  end

  // The buffer never reports more results than it holds.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    buf_cnt_r <= RES_CNT_W'(MAX_RES))
    else $error("result buffer count out of range");

  // While collecting, fewer bytes are held than the lead calls for.
  a_utf_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_UTF) |-> ((need_r != 2'd0) && (held_r < need_r)))
    else $error("inconsistent sequence counters");

  // A byte closing a percent escape always yields a result next cycle.
  a_pct2_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (mode_r == MODE_PCT2)) |=> out_tvalid)
    else $error("percent escape gave no result");

  // A drained result advances the read pointer by one.
  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && (buf_cnt_r > RES_CNT_W'(1))) |=> (buf_idx_r == $past(buf_idx_r) + RES_IDX_W'(1)))
    else $error("result buffer pointer slipped");

endmodule
